/* rtl/mcd7_pkg.sv */
// Shared types and constants for the Mcoded7 group decoder.
package mcd7_pkg;

  localparam int CodeW    = 8;             // width of a coded or decoded byte
  localparam int DataW    = 7;             // payload bits of a coded byte
  localparam int GroupMax = 7;             // body bytes per full group
  localparam int CountW   = 3;             // holds 0..GroupMax

  // Front phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_DROP   = 2'd2
  } phase_t;

  // One finished group, or one error marker, handed from front to back
  typedef struct packed {
    logic [GroupMax-1:0][DataW-1:0] body;    // body bytes, entry 0 first
    logic [DataW-1:0]               header;  // right-aligned top bits
    logic [CountW-1:0]              count;   // number of bytes to emit, 1..7
    logic                           last;    // group ends the message
    logic                           err;     // error marker, emits one item
  } group_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic avail;
  } qstat_t;

endpackage

/* rtl/mcd7_ifs.sv */
// Valid/ready channel interfaces for coded input and decoded output items.
interface mcd7_in_if;
  logic                          valid;
  logic                          ready;
  logic [mcd7_pkg::CodeW-1:0]    coded_byte;
  logic                          message_end;

  modport source (output valid, output coded_byte, output message_end, input ready);
  modport sink   (input valid, input coded_byte, input message_end, output ready);
endinterface

interface mcd7_out_if;
  logic                          valid;
  logic                          ready;
  logic [mcd7_pkg::CodeW-1:0]    plain_byte;
  logic                          final_flag;
  logic                          bad_coding;

  modport source (output valid, output plain_byte, output final_flag, output bad_coding,
                  input ready);
  modport sink   (input valid, input plain_byte, input final_flag, input bad_coding,
                  output ready);
endinterface

/* rtl/mcd7_front.sv */
// Front end: accepts coded bytes, tracks header/body phase, collects groups.
module mcd7_front (
  input  logic                clk,
  input  logic                rst,
  mcd7_in_if.sink             coded,
  input  mcd7_pkg::qstat_t    qstat,
  output logic                push,
  output mcd7_pkg::group_t    rec
);

  mcd7_pkg::phase_t                   phase, phase_next;
  logic [mcd7_pkg::DataW-1:0]         header_bits, header_bits_next;
  logic [mcd7_pkg::CountW-1:0]        body_count, body_count_next;
  logic [mcd7_pkg::DataW-1:0]         store [mcd7_pkg::GroupMax];
  logic [mcd7_pkg::GroupMax-1:0][mcd7_pkg::DataW-1:0] merged;
  logic                               take;
  logic                               top_set;
  logic                               store_we;

  // Bytes are taken whenever the queue can absorb a finished group
  assign coded.ready = !qstat.full;
  assign take        = coded.valid && coded.ready;
  assign top_set     = coded.coded_byte[mcd7_pkg::CodeW-1];

  // Buffered body with the current byte dropped into its slot
  always_comb begin
    for (int i = 0; i < mcd7_pkg::GroupMax; i++) begin
      merged[i] = (mcd7_pkg::CountW'(i) == body_count) ?
                  coded.coded_byte[mcd7_pkg::DataW-1:0] : store[i];
    end
  end

  // Phase control and group hand-off
  always_comb begin
    phase_next       = phase;
    header_bits_next = header_bits;
    body_count_next  = body_count;
    store_we         = 1'b0;
    push             = 1'b0;
    rec.body         = merged;
    rec.header       = header_bits;
    rec.count        = body_count + mcd7_pkg::CountW'(1);
    rec.last         = coded.message_end;
    rec.err          = 1'b0;
    if (take) begin
      unique case (phase)
        mcd7_pkg::PH_DROP: begin
          if (coded.message_end) phase_next = mcd7_pkg::PH_HEADER;
        end
        mcd7_pkg::PH_BODY: begin
          if (top_set) begin
            push            = 1'b1;
            rec.err         = 1'b1;
            body_count_next = '0;
            phase_next      = coded.message_end ? mcd7_pkg::PH_HEADER : mcd7_pkg::PH_DROP;
          end else begin
            store_we = 1'b1;
            if (rec.count == mcd7_pkg::CountW'(mcd7_pkg::GroupMax) || coded.message_end) begin
              push            = 1'b1;
              body_count_next = '0;
              phase_next      = mcd7_pkg::PH_HEADER;
            end else begin
              body_count_next = rec.count;
            end
          end
        end
        default: begin
          // expecting a header byte
          if (top_set || coded.message_end) begin
            push       = 1'b1;
            rec.err    = 1'b1;
            phase_next = coded.message_end ? mcd7_pkg::PH_HEADER : mcd7_pkg::PH_DROP;
          end else begin
            header_bits_next = coded.coded_byte[mcd7_pkg::DataW-1:0];
            body_count_next  = '0;
            phase_next       = mcd7_pkg::PH_BODY;
          end
        end
      endcase
      // error marker carries a single zero item
      if (rec.err) begin
        rec.body   = '0;
        rec.header = '0;
        rec.count  = mcd7_pkg::CountW'(1);
        rec.last   = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= mcd7_pkg::PH_HEADER;
      header_bits <= '0;
      body_count  <= '0;
    end else begin
      phase       <= phase_next;
      header_bits <= header_bits_next;
      body_count  <= body_count_next;
    end
  end

  // Body buffer, no reset
  always_ff @(posedge clk) begin
    if (store_we) store[body_count] <= coded.coded_byte[mcd7_pkg::DataW-1:0];
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    body_count < mcd7_pkg::CountW'(mcd7_pkg::GroupMax))
    else $error("body count reached a full group without hand-off");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    push |-> (rec.count != '0 && rec.count <= mcd7_pkg::CountW'(mcd7_pkg::GroupMax)))
    else $error("group handed off with bad length");

endmodule

/* rtl/mcd7_queue.sv */
// Two-entry queue of finished groups between front and back.
module mcd7_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mcd7_pkg::group_t    wr_rec,
  input  logic                pop,
  output mcd7_pkg::group_t    head,
  output mcd7_pkg::qstat_t    qstat
);

  mcd7_pkg::group_t mem [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       fill;

  assign head        = mem[rd_ptr];
  assign qstat.full  = fill == 2'd2;
  assign qstat.avail = fill != 2'd0;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_rec;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !qstat.full)
    else $error("push into full group queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> qstat.avail)
    else $error("pop from empty group queue");

endmodule

/* rtl/mcd7_back.sv */
// Back end: walks the head group and emits one decoded byte per item.
module mcd7_back (
  input  logic                clk,
  input  logic                rst,
  input  mcd7_pkg::group_t    head,
  input  mcd7_pkg::qstat_t    qstat,
  output logic                pop,
  mcd7_out_if.source          decoded
);

  logic [mcd7_pkg::CountW-1:0] k;
  logic [mcd7_pkg::CountW-1:0] last_k;
  logic [mcd7_pkg::CountW-1:0] hsel;
  logic                        advance;
  logic                        at_last;
  logic [mcd7_pkg::CodeW-1:0]  byte_next;

  // Step when a group is waiting and the output register is free
  assign advance = qstat.avail && (!decoded.valid || decoded.ready);
  assign last_k  = head.count - mcd7_pkg::CountW'(1);
  assign at_last = k == last_k;
  assign pop     = advance && at_last;
  // header bit n-1-k restores the top bit of byte k
  assign hsel    = last_k - k;
  assign byte_next = head.err ? '0 : {head.header[hsel], head.body[k]};

  // Byte index within the head group
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (advance) begin
      k <= at_last ? '0 : k + mcd7_pkg::CountW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      decoded.valid <= 1'b0;
    end else if (advance) begin
      decoded.valid <= 1'b1;
    end else if (decoded.ready) begin
      decoded.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      decoded.plain_byte <= byte_next;
      decoded.final_flag <= head.err || (head.last && at_last);
      decoded.bad_coding <= head.err;
    end
  end

  a_err_item: assert property (@(posedge clk) disable iff (rst)
    (decoded.valid && decoded.bad_coding) |-> (decoded.final_flag && decoded.plain_byte == '0))
    else $error("error item must be final and zero");
  a_k_in_group: assert property (@(posedge clk) disable iff (rst)
    qstat.avail |-> k < head.count)
    else $error("byte index beyond group length");

endmodule

/* rtl/mcoded7_group_decoder.sv */
// Top level of the Mcoded7 group decoder.
// Takes one coded byte per cycle while the two-entry group queue has room, and
// emits one decoded byte per cycle from the back end while the output is ready.
// A group of n body bytes (after its header) leaves as n items, one per cycle,
// in step with the next group arriving; the front stalls only when both queue
// entries hold groups not yet fully emitted. A malformed message gives one item
// with bad_coding and final_flag set, plain_byte zero; the rest of that message
// is swallowed. Groups pass through the queue, then the output register.
module mcoded7_group_decoder (
  input  logic         clk,
  input  logic         rst,
  mcd7_in_if.sink      coded,
  mcd7_out_if.source   decoded
);

  logic               push;
  logic               pop;
  mcd7_pkg::group_t   wr_rec;
  mcd7_pkg::group_t   head;
  mcd7_pkg::qstat_t   qstat;

  mcd7_front u_front (
    .clk   (clk),
    .rst   (rst),
    .coded (coded),
    .qstat (qstat),
    .push  (push),
    .rec   (wr_rec)
  );

  mcd7_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .head   (head),
    .qstat  (qstat)
  );

  mcd7_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .qstat   (qstat),
    .pop     (pop),
    .decoded (decoded)
  );

endmodule

/* bench/tb.sv */
// Self-checking testbench for the Mcoded7 group decoder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 1000;  // cycles with no item moving on either side
  localparam int HoldCycles = 40;    // long receiver hold-off
  localparam int HoldAt     = 80;    // coded items in before the hold-off starts
  localparam int CalmFrom   = 140;   // window with no idling on either side
  localparam int CalmTo     = 200;
  localparam int TailCycles = 20;
  localparam int ItemTarget = 260;

  typedef struct packed {
    logic [mcd7_pkg::CodeW-1:0] data;
    logic                       last;
  } coded_t;

  typedef struct packed {
    logic [mcd7_pkg::CodeW-1:0] plain;
    logic                       fin;
    logic                       bad;
  } plain_t;

  logic clk;
  logic rst;

  mcd7_in_if  coded_if ();
  mcd7_out_if decoded_if ();

  mcoded7_group_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .coded   (coded_if),
    .decoded (decoded_if)
  );

  coded_t pending_q[$];   // coded items still to be offered
  plain_t decoded_q[$];   // decoded items the block owes

  // Decoder state mirrored by the predictor
  mcd7_pkg::phase_t           dec_phase;
  logic [mcd7_pkg::DataW-1:0] grp_header;
  logic [mcd7_pkg::DataW-1:0] grp_body [mcd7_pkg::GroupMax];
  int unsigned                grp_count;

  int  n_in;
  int  n_out;
  int  n_bad;
  int  n_fail;
  int  stall_cycles;
  int  hold_left;
  bit  hold_done;
  bit  took_in;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Malformed input: one error item marked last, then drop or restart
  task automatic flag_bad(input logic at_end);
    plain_t r;
    r = '{plain: '0, fin: 1'b1, bad: 1'b1};
    decoded_q = {decoded_q, r};
    dec_phase = at_end ? mcd7_pkg::PH_HEADER : mcd7_pkg::PH_DROP;
    grp_count = 0;
  endtask

  // Predict the decoded items caused by one accepted coded item
  task automatic decode_byte(input coded_t it);
    plain_t r;
    int     n;
    case (dec_phase)
      mcd7_pkg::PH_DROP: begin
        if (it.last) dec_phase = mcd7_pkg::PH_HEADER;
      end
      mcd7_pkg::PH_BODY: begin
        if (it.data[mcd7_pkg::CodeW-1]) begin
          flag_bad(it.last);
        end else begin
          grp_body[grp_count] = it.data[mcd7_pkg::DataW-1:0];
          grp_count++;
          if (grp_count == mcd7_pkg::GroupMax || it.last) begin
            n = grp_count;
            for (int k = 0; k < n; k++) begin
              r.plain = {grp_header[n-1-k], grp_body[k]};
              r.fin   = it.last && (k == n - 1);
              r.bad   = 1'b0;
              decoded_q = {decoded_q, r};
            end
            grp_count = 0;
            dec_phase = mcd7_pkg::PH_HEADER;
          end
        end
      end
      default: begin
        if (it.data[mcd7_pkg::CodeW-1] || it.last) begin
          flag_bad(it.last);
        end else begin
          grp_header = it.data[mcd7_pkg::DataW-1:0];
          grp_count  = 0;
          dec_phase  = mcd7_pkg::PH_BODY;
        end
      end
    endcase
  endtask

  task automatic push_item(input logic [mcd7_pkg::CodeW-1:0] data, input logic last);
    coded_t it;
    it.data = data;
    it.last = last;
    pending_q = {pending_q, it};
  endtask

  // One random message of coded items
  task automatic add_message();
    coded_t msg[$];
    coded_t it;
    int     groups;
    int     len;
    int     kind;
    int     pos;
    groups = $urandom_range(1, 3);
    kind   = $urandom_range(99);
    it.last = 1'b0;
    if (kind >= 90) begin
      // noise: raw bytes, top bit at random
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        it.data = mcd7_pkg::CodeW'($urandom);
        msg = {msg, it};
      end
    end else begin
      for (int g = 0; g < groups; g++) begin
        it.data = {1'b0, mcd7_pkg::DataW'($urandom)};
        msg = {msg, it};
        if (kind >= 82 && g == groups - 1) break;  // header closes the message
        len = (g == groups - 1) ? $urandom_range(1, mcd7_pkg::GroupMax) : mcd7_pkg::GroupMax;
        for (int i = 0; i < len; i++) begin
          it.data = {1'b0, mcd7_pkg::DataW'($urandom)};
          msg = {msg, it};
        end
      end
    end
    msg[msg.size()-1].last = 1'b1;
    // stray top bit in a header or body byte
    if (kind >= 70 && kind < 82) begin
      pos = $urandom_range(0, msg.size() - 1);
      msg[pos].data[mcd7_pkg::CodeW-1] = 1'b1;
    end
    foreach (msg[i]) pending_q = {pending_q, msg[i]};
  endtask

  // Stimulus, drain and verdict
  initial begin
    rst = 1'b1;
    coded_if.valid       = 1'b0;
    coded_if.coded_byte  = '0;
    coded_if.message_end = 1'b0;
    decoded_if.ready     = 1'b0;
    dec_phase  = mcd7_pkg::PH_HEADER;
    grp_header = '0;
    grp_count  = 0;

    // full group ending the message, extreme body values
    push_item(8'h2A, 1'b0);
    push_item(8'h7F, 1'b0); push_item(8'h00, 1'b0); push_item(8'h55, 1'b0);
    push_item(8'h2A, 1'b0); push_item(8'h01, 1'b0); push_item(8'h40, 1'b0);
    push_item(8'h7E, 1'b1);
    // short group: header bits above the group length are ignored
    push_item(8'h7F, 1'b0); push_item(8'h11, 1'b0); push_item(8'h22, 1'b1);
    // header alone at the message end
    push_item(8'h00, 1'b1);
    // header with top bit set, rest of the message dropped
    push_item(8'h80, 1'b0); push_item(8'h05, 1'b0); push_item(8'h06, 1'b1);
    // body top bit mid message, earlier bytes discarded
    push_item(8'h01, 1'b0); push_item(8'h33, 1'b0); push_item(8'h99, 1'b0);
    push_item(8'h12, 1'b0); push_item(8'h00, 1'b1);
    // bad header that also ends the message
    push_item(8'hFF, 1'b1);
    // bad body byte on the message end
    push_item(8'h3F, 1'b0); push_item(8'h80, 1'b1);

    while (pending_q.size() < ItemTarget) add_message();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while ((pending_q.size() != 0 || decoded_q.size() != 0) && stall_cycles < StallLimit)
      @(posedge clk);

    if (stall_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      repeat (TailCycles) @(posedge clk);
      if (decoded_q.size() != 0) begin
        $error("%0d decoded items never arrived", decoded_q.size());
        n_fail++;
      end
      $display("Run covered %0d coded items and %0d decoded items, %0d of them error markers,",
               n_in, n_out, n_bad);
      $display("with random gaps, a no-gap stretch and a %0d-cycle output hold-off.",
               HoldCycles);
      if (n_fail == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
      $finish;
    end
  end

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    plain_t got;
    plain_t want;
    bit     moved;
    moved   = 1'b0;
    took_in = 1'b0;
    if (!rst && coded_if.valid && coded_if.ready) begin
      decode_byte(pending_q.pop_front());
      took_in = 1'b1;
      moved   = 1'b1;
      n_in++;
    end
    if (!rst && decoded_if.valid && decoded_if.ready) begin
      moved = 1'b1;
      n_out++;
      got = '{plain: decoded_if.plain_byte, fin: decoded_if.final_flag,
              bad: decoded_if.bad_coding};
      if (got.bad) n_bad++;
      if (decoded_q.size() == 0) begin
        $error("unexpected decoded item: plain_byte %h final_flag %b bad_coding %b",
               got.plain, got.fin, got.bad);
        n_fail++;
      end else begin
        want = decoded_q.pop_front();
        if (got.plain !== want.plain) begin
          $error("plain_byte: expected %h, got %h", want.plain, got.plain);
          n_fail++;
        end
        if (got.fin !== want.fin) begin
          $error("final_flag: expected %b, got %b", want.fin, got.fin);
          n_fail++;
        end
        if (got.bad !== want.bad) begin
          $error("bad_coding: expected %b, got %b", want.bad, got.bad);
          n_fail++;
        end
      end
    end
    if (rst || moved) stall_cycles = 0;
    else stall_cycles++;
  end

  // Input side: hold an offered item until taken, otherwise maybe idle
  always @(negedge clk) begin
    bit calm;
    calm = (n_in >= CalmFrom && n_in < CalmTo);
    if (rst) begin
      coded_if.valid <= 1'b0;
    end else if (coded_if.valid && !took_in) begin
      // item still on offer
    end else if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
      coded_if.valid       <= 1'b1;
      coded_if.coded_byte  <= pending_q[0].data;
      coded_if.message_end <= pending_q[0].last;
    end else begin
      coded_if.valid <= 1'b0;
    end
  end

  // Output side: random stalls, one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      decoded_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      decoded_if.ready <= 1'b0;
    end else if (!hold_done && n_in >= HoldAt) begin
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
      decoded_if.ready <= 1'b0;
    end else begin
      decoded_if.ready <= (n_in >= CalmFrom && n_in < CalmTo) || ($urandom_range(99) >= 38);
    end
  end

endmodule

/* files.f */
rtl/mcd7_pkg.sv
rtl/mcd7_ifs.sv
rtl/mcd7_front.sv
rtl/mcd7_queue.sv
rtl/mcd7_back.sv
rtl/mcoded7_group_decoder.sv
bench/tb.sv
